FILE: hw/rtl/greedy_cycle_tour_builder_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the greedy cycle tour builder
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef GREEDY_CYCLE_TOUR_BUILDER_UNIT_DEFINES_SVH
`define GREEDY_CYCLE_TOUR_BUILDER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset
`define GCTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define GCTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gctb_pkg.sv
// ---------------------------------------------------------------------------
// gctb_pkg
// Shared codes and types of the greedy cycle tour builder.
// ---------------------------------------------------------------------------
`default_nettype none

package gctb_pkg;

  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 9;
  localparam int NODE_W    = 8;
  localparam int VALUE_W   = 16;
  localparam int SIZE_W    = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_DIST = 2'd0,
    ACT_LOAD_COST = 2'd1,
    ACT_BUILD     = 2'd2,
    ACT_READ      = 2'd3
  } action_e;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOUR_LENGTH = 2'd1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_B_INIT,
    ST_I_ADDR,
    ST_I_D1,
    ST_I_CMP,
    ST_I_DONE,
    ST_LOOP,
    ST_P_CHK,
    ST_J_TOUR,
    ST_J_D1,
    ST_J_D2,
    ST_J_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/gctb_ram.sv
// ---------------------------------------------------------------------------
// gctb_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module gctb_ram #(
  parameter int DW = 16,
  parameter int AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/greedy_cycle_tour_builder_unit.sv
// ---------------------------------------------------------------------------
// greedy_cycle_tour_builder_unit
// Cheapest-insertion tour builder with node costs over a loaded distance matrix.
// ---------------------------------------------------------------------------
// A load word (distance, node cost) is answered straight from idle; a read of a
// tour position passes through ST_READ first. A build walks the state through
// the single read port of the distance RAM: a round trip scan over all nodes
// picks the second node, then each insertion step checks every node, walks every
// tour edge for each unvisited node and shifts the tour entries behind the
// insertion point up one place. One word is handled at a time; the result
// register frees the input as soon as the previous result is taken.
`default_nettype none

`include "greedy_cycle_tour_builder_unit_defines.svh"

module greedy_cycle_tour_builder_unit #(
  parameter int MAX_NODES = 256,
  parameter int DIST_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gctb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gctb_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [gctb_pkg::ACT_W-1:0]       action_i,
  input  logic [gctb_pkg::NODE_W-1:0]      src_node_i,
  input  logic [gctb_pkg::NODE_W-1:0]      to_node_i,
  input  logic [gctb_pkg::VALUE_W-1:0]     value_i,
  input  logic [gctb_pkg::NODE_W-1:0]      start_node_i,
  input  logic [gctb_pkg::NODE_W-1:0]      position_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [gctb_pkg::NODE_W-1:0]      node_o,
  output logic [gctb_pkg::SIZE_W-1:0]      tour_size_o,
  output logic                             status_o
);

  import gctb_pkg::*;

  localparam int NW   = $clog2(MAX_NODES);
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int VW   = (DIST_BITS > VALUE_W) ? DIST_BITS : VALUE_W;
  localparam int SW   = VW + 3;

  // Control state
  state_e               state_q, state_d;
  logic [CFG_W-1:0]     node_count_q, tour_length_q;
  logic [CW-1:0]        count_q, count_d;
  logic [MAX_NODES-1:0] visited_q, visited_d;
  logic                 out_valid_q, out_valid_d;

  // Build datapath
  logic [CW-1:0]        n_q, n_d, iter_q, iter_d, j_q, j_d, size_q, size_d, at_q, at_d;
  logic [CFG_W-1:0]     len_q, len_d;
  logic [NW-1:0]        start_q, start_d, a_q, a_d, b_q, b_d, pick_q, pick_d;
  logic [DIST_BITS-1:0] dap_q, dap_d, dpb_q, dpb_d;
  logic signed [SW-1:0] best_q, best_d, cand;
  logic                 found_q, found_d, bad_q, bad_d;
  logic [NODE_W-1:0]    node_q, node_d;
  logic                 status_q, status_d;

  // Memory ports
  logic                 dist_we, dist_re, cost_we, cost_re, tour_we, tour_re;
  logic [2*NW-1:0]      dist_waddr, dist_raddr;
  logic [DIST_BITS-1:0] dist_rdata;
  logic [NW-1:0]        cost_raddr, tour_waddr, tour_raddr;
  logic [VALUE_W-1:0]   cost_rdata;
  logic [NW-1:0]        tour_wdata, tour_rdata;

  logic                 in_acc;
  logic [CW-1:0]        n_calc;
  logic [NW-1:0]        from_idx, to_idx, iter_idx;
  logic                 from_ok, to_ok;
  logic [CW-1:0]        j_next;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign from_idx    = NW'(src_node_i);
  assign to_idx      = NW'(to_node_i);
  assign from_ok     = 32'(src_node_i) < MAX_NODES;
  assign to_ok       = 32'(to_node_i) < MAX_NODES;
  assign n_calc      = (32'(node_count_q) < MAX_NODES) ? CW'(node_count_q) : CW'(MAX_NODES);
  assign iter_idx    = iter_q[NW-1:0];
  assign j_next      = j_q + CW'(1);

  gctb_ram #(.DW(DIST_BITS), .AW(2*NW)) u_dist_ram (
    .clk_i, .we_i(dist_we), .waddr_i(dist_waddr), .wdata_i(DIST_BITS'(value_i)),
    .re_i(dist_re), .raddr_i(dist_raddr), .rdata_o(dist_rdata)
  );

  gctb_ram #(.DW(VALUE_W), .AW(NW)) u_cost_ram (
    .clk_i, .we_i(cost_we), .waddr_i(from_idx), .wdata_i(value_i),
    .re_i(cost_re), .raddr_i(cost_raddr), .rdata_o(cost_rdata)
  );

  gctb_ram #(.DW(NW), .AW(NW)) u_tour_ram (
    .clk_i, .we_i(tour_we), .waddr_i(tour_waddr), .wdata_i(tour_wdata),
    .re_i(tour_re), .raddr_i(tour_raddr), .rdata_o(tour_rdata)
  );

  // Next state, memory control and datapath updates
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    visited_d   = visited_q;
    out_valid_d = out_valid_q && !out_ready_i;
    n_d = n_q;  iter_d = iter_q;  j_d = j_q;  size_d = size_q;  at_d = at_q;
    len_d = len_q;  start_d = start_q;  a_d = a_q;  b_d = b_q;  pick_d = pick_q;
    dap_d = dap_q;  dpb_d = dpb_q;  best_d = best_q;  found_d = found_q;  bad_d = bad_q;
    node_d = node_q;  status_d = status_q;
    dist_we = 1'b0;  dist_re = 1'b0;  cost_we = 1'b0;  cost_re = 1'b0;
    tour_we = 1'b0;  tour_re = 1'b0;
    dist_waddr = {from_idx, to_idx};
    dist_raddr = {start_q, iter_idx};
    cost_raddr = iter_idx;
    tour_waddr = '0;
    tour_wdata = start_q;
    tour_raddr = '0;
    cand       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_i)
            ACT_LOAD_DIST: begin
              dist_we     = from_ok && to_ok;
              node_d      = '0;
              status_d    = (from_ok && to_ok) ? STATUS_OK : STATUS_ERR;
              out_valid_d = 1'b1;
            end
            ACT_LOAD_COST: begin
              cost_we     = from_ok;
              node_d      = '0;
              status_d    = from_ok ? STATUS_OK : STATUS_ERR;
              out_valid_d = 1'b1;
            end
            ACT_BUILD: begin
              n_d     = n_calc;
              len_d   = tour_length_q;
              start_d = NW'(start_node_i);
              bad_d   = 32'(start_node_i) >= 32'(n_calc);
              state_d = ST_B_INIT;
            end
            default: begin
              tour_re    = 1'b1;
              tour_raddr = NW'(position_i);
              bad_d      = !((32'(position_i) < 32'(count_q)) &&
                             (32'(position_i) < MAX_NODES));
              state_d    = ST_READ;
            end
          endcase
        end
      end

      // Return the tour entry
      ST_READ: begin
        node_d      = bad_q ? '0 : NODE_W'(tour_rdata);
        status_d    = bad_q ? STATUS_ERR : STATUS_OK;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end

      // Drop old marks and, for a valid start and nonzero tour length, place the start node
      ST_B_INIT: begin
        visited_d = '0;
        if (bad_q) begin
          count_d = '0;
          state_d = ST_FINISH;
        end else if ((n_q < CW'(2)) || (len_q < CFG_W'(2))) begin
          if (len_q != '0) begin
            tour_we            = 1'b1;
            visited_d[start_q] = 1'b1;
            count_d            = CW'(1);
          end else begin
            count_d = '0;
          end
          state_d = ST_FINISH;
        end else begin
          tour_we            = 1'b1;
          visited_d[start_q] = 1'b1;
          iter_d             = '0;
          found_d            = 1'b0;
          state_d            = ST_I_ADDR;
        end
      end

      // Round trip scan: fetch d[s][i] and cost[i], then d[i][s]
      ST_I_ADDR: begin
        if (iter_q == n_q) begin
          state_d = ST_I_DONE;
        end else if (iter_idx == start_q) begin
          iter_d = iter_q + CW'(1);
        end else begin
          dist_re = 1'b1;
          cost_re = 1'b1;
          state_d = ST_I_D1;
        end
      end

      ST_I_D1: begin
        dap_d      = dist_rdata;
        dist_re    = 1'b1;
        dist_raddr = {iter_idx, start_q};
        state_d    = ST_I_CMP;
      end

      ST_I_CMP: begin
        cand = $signed(SW'(dap_q)) + $signed(SW'(dist_rdata)) + $signed(SW'(cost_rdata));
        if (!found_q || (cand < best_q)) begin
          found_d = 1'b1;
          best_d  = cand;
          pick_d  = iter_idx;
        end
        iter_d  = iter_q + CW'(1);
        state_d = ST_I_ADDR;
      end

      ST_I_DONE: begin
        tour_we           = 1'b1;
        tour_waddr        = NW'(1);
        tour_wdata        = pick_q;
        visited_d[pick_q] = 1'b1;
        size_d            = CW'(2);
        state_d           = ST_LOOP;
      end

      // Start another insertion step or stop
      ST_LOOP: begin
        if (32'(size_q) < 32'(len_q)) begin
          iter_d  = '0;
          found_d = 1'b0;
          state_d = ST_P_CHK;
        end else begin
          count_d = size_q;
          state_d = ST_FINISH;
        end
      end

      // Skip visited nodes, fetch the cost of the next candidate
      ST_P_CHK: begin
        if (iter_q == n_q) begin
          if (found_q) begin
            j_d     = size_q;
            state_d = ST_SH_RD;
          end else begin
            count_d = size_q;
            state_d = ST_FINISH;
          end
        end else if (visited_q[iter_idx]) begin
          iter_d = iter_q + CW'(1);
        end else begin
          cost_re = 1'b1;
          a_d     = start_q;
          j_d     = '0;
          state_d = ST_J_TOUR;
        end
      end

      // Edge walk: fetch b and d[a][p]
      ST_J_TOUR: begin
        tour_re    = 1'b1;
        tour_raddr = (j_next == size_q) ? '0 : j_next[NW-1:0];
        dist_re    = 1'b1;
        dist_raddr = {a_q, iter_idx};
        state_d    = ST_J_D1;
      end

      ST_J_D1: begin
        b_d        = tour_rdata;
        dap_d      = dist_rdata;
        dist_re    = 1'b1;
        dist_raddr = {iter_idx, tour_rdata};
        state_d    = ST_J_D2;
      end

      ST_J_D2: begin
        dpb_d      = dist_rdata;
        dist_re    = 1'b1;
        dist_raddr = {a_q, b_q};
        state_d    = ST_J_CMP;
      end

      ST_J_CMP: begin
        cand = $signed(SW'(dap_q)) + $signed(SW'(dpb_q)) - $signed(SW'(dist_rdata))
             + $signed(SW'(cost_rdata));
        if (!found_q || (cand < best_q)) begin
          found_d = 1'b1;
          best_d  = cand;
          pick_d  = iter_idx;
          at_d    = j_next;
        end
        a_d = b_q;
        j_d = j_next;
        if (j_next == size_q) begin
          iter_d  = iter_q + CW'(1);
          state_d = ST_P_CHK;
        end else begin
          state_d = ST_J_TOUR;
        end
      end

      // Shift the tail up one place, then insert
      ST_SH_RD: begin
        if (j_q > at_q) begin
          tour_re    = 1'b1;
          tour_raddr = NW'(j_q - CW'(1));
          state_d    = ST_SH_WR;
        end else begin
          tour_we           = 1'b1;
          tour_waddr        = at_q[NW-1:0];
          tour_wdata        = pick_q;
          visited_d[pick_q] = 1'b1;
          size_d            = size_q + CW'(1);
          state_d           = ST_LOOP;
        end
      end

      ST_SH_WR: begin
        tour_we    = 1'b1;
        tour_waddr = j_q[NW-1:0];
        tour_wdata = tour_rdata;
        j_d        = j_q - CW'(1);
        state_d    = ST_SH_RD;
      end

      ST_FINISH: begin
        node_d      = '0;
        status_d    = bad_q ? STATUS_ERR : STATUS_OK;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      visited_q     <= '0;
      out_valid_q   <= 1'b0;
      node_count_q  <= '0;
      tour_length_q <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      visited_q   <= visited_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && (cfg_index_i == REG_NODE_COUNT)) begin
        node_count_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == REG_TOUR_LENGTH)) begin
        tour_length_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q <= n_d;  iter_q <= iter_d;  j_q <= j_d;  size_q <= size_d;  at_q <= at_d;
    len_q <= len_d;  start_q <= start_d;  a_q <= a_d;  b_q <= b_d;  pick_q <= pick_d;
    dap_q <= dap_d;  dpb_q <= dpb_d;  best_q <= best_d;  found_q <= found_d;
    bad_q <= bad_d;  node_q <= node_d;  status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign node_o      = node_q;
  assign tour_size_o = SIZE_W'(count_q);
  assign status_o    = status_q;

  `GCTB_ASSERT(a_ready_only_idle, !in_ready_o || (state_q == ST_IDLE), "ready outside idle")
  `GCTB_ASSERT(a_count_bound, count_q <= CW'(MAX_NODES), "tour count beyond node limit")
  `GCTB_ASSERT_NEXT(a_build_no_result, in_acc && (action_i == ACT_BUILD),
                    !out_valid_o, "result during build start")
  `GCTB_ASSERT_NEXT(a_insert_marks, (state_q == ST_SH_RD) && (j_q <= at_q),
                    visited_q[$past(pick_q)], "inserted node not marked")

endmodule

`default_nettype wire
